FILE: hw/rtl/b64ld_pkg.sv
// Shared types, constants and the character map of the lenient Base64 decoder.
package b64ld_pkg;

	// Pad character of the Base64 alphabet.
	localparam logic [7:0] PAD_CHAR = 8'h3D;

	// Depth of the result queue and the width of its fill count (holds 0..RES_DEPTH).
	localparam int RES_DEPTH = 4;
	localparam int CNT_W     = $clog2(RES_DEPTH + 1);

	// Largest number of results that one character can produce.
	localparam int MAX_RES = 3;

	// One decoded result as it leaves the block.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_message;
		logic       length_error;
	} result_t;

	// Lenient map from a raw character to its six-bit value. Unknown characters give zero.
	function automatic logic [5:0] map_char(input logic [7:0] c);
		logic [7:0] t;
		t = 8'h00;
		if (c >= 8'h41 && c <= 8'h5A) begin
			t = c - 8'h41;
		end else if (c >= 8'h61 && c <= 8'h7A) begin
			t = c - 8'h61 + 8'd26;
		end else if (c >= 8'h30 && c <= 8'h39) begin
			t = c - 8'h30 + 8'd52;
		end else if (c == 8'h2B || c == 8'h2D || c == 8'h2E) begin
			t = 8'd62;
		end else if (c == 8'h2F || c == 8'h2C || c == 8'h5F) begin
			t = 8'd63;
		end
		return t[5:0];
	endfunction

endpackage

FILE: hw/rtl/base64_lenient_decoder_core.sv
// Top level of the lenient Base64 decoder: character stream in, byte stream out.
//
// Usage. One Base64 character enters per request on the slave stream
// (s_axis_*); s_axis_tlast marks the last character of a message. Decoded
// bytes leave on the master stream (m_axis_*), most significant byte of each
// quad first. m_axis_tlast is set on the final byte of a message, and
// m_axis_tuser flags a message whose length is not a multiple of four; that
// error request carries a zero byte and ends the message. Bytes already sent
// for a bad message are not recalled, so the consumer drops them.
//
// Throughput. A result enters the registered result queue when the character
// that causes it is taken. While the queue has room the input side takes one
// character per cycle; with m_axis_tready high, a quad's three bytes drain
// from the four-entry result queue at one byte per cycle, covered by the next
// quad's characters, so a continuous stream runs at one character per cycle.
//
// Stalls. When the receiver holds m_axis_tready low the queue fills, and
// s_axis_tready drops only when the next character could produce more
// results than the queue has free (three for a quad-completing character,
// one otherwise). Reset empties the queue and restarts quad assembly.
module base64_lenient_decoder_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] char_in
	input  logic       s_axis_tlast,   // is_last
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // [7:0] data_byte
	output logic       m_axis_tlast,   // end_of_message
	output logic       m_axis_tuser    // [0] length_error
);

	localparam int CW = b64ld_pkg::CNT_W;

	// Quad assembly state.
	logic [1:0]  pos_q;
	logic [17:0] acc_q;
	logic        third_pad_q;

	// Result queue: entry 0 is the head.
	b64ld_pkg::result_t res_q [b64ld_pkg::RES_DEPTH];
	b64ld_pkg::result_t res_d [b64ld_pkg::RES_DEPTH];
	logic [CW-1:0]      cnt_q;
	logic [CW-1:0]      cnt_d;

	logic          pop;
	logic          accept;
	logic [CW-1:0] cnt_ap;
	logic [5:0]    sextet;
	logic          is_pad;
	logic [1:0]    push_cnt;
	logic [23:0]   quad_bits;
	b64ld_pkg::result_t new_res [b64ld_pkg::MAX_RES];

	assign m_axis_tvalid = (cnt_q != '0);
	assign m_axis_tdata  = res_q[0].data_byte;
	assign m_axis_tlast  = res_q[0].end_of_message;
	assign m_axis_tuser  = res_q[0].length_error;

	assign pop    = m_axis_tvalid & m_axis_tready;
	assign cnt_ap = cnt_q - CW'(pop);

	// A quad-completing character needs room for three results, any other for one.
	always_comb begin
		if (pos_q == 2'd3) begin
			s_axis_tready = (cnt_ap <= CW'(b64ld_pkg::RES_DEPTH - b64ld_pkg::MAX_RES));
		end else begin
			s_axis_tready = (cnt_ap <= CW'(b64ld_pkg::RES_DEPTH - 1));
		end
	end

	assign accept    = s_axis_tvalid & s_axis_tready;
	assign sextet    = b64ld_pkg::map_char(s_axis_tdata);
	assign is_pad    = (s_axis_tdata == b64ld_pkg::PAD_CHAR);
	assign quad_bits = {acc_q, sextet};

	// Results produced by the character being taken.
	always_comb begin
		push_cnt = 2'd0;
		for (int k = 0; k < b64ld_pkg::MAX_RES; k++) begin
			new_res[k] = '0;
		end
		if (accept) begin
			if (pos_q == 2'd3) begin
				if (s_axis_tlast && is_pad) begin
					push_cnt = third_pad_q ? 2'd1 : 2'd2;
				end else begin
					push_cnt = 2'd3;
				end
				new_res[0].data_byte = quad_bits[23:16];
				new_res[1].data_byte = quad_bits[15:8];
				new_res[2].data_byte = quad_bits[7:0];
				for (int k = 0; k < b64ld_pkg::MAX_RES; k++) begin
					new_res[k].end_of_message = s_axis_tlast && (push_cnt == 2'(k + 1));
				end
			end else if (s_axis_tlast) begin
				// Message ends inside a quad: a single error result.
				push_cnt                  = 2'd1;
				new_res[0].end_of_message = 1'b1;
				new_res[0].length_error   = 1'b1;
			end
		end
	end

	// Queue update: shift out the head on a pop, then append behind the survivors.
	always_comb begin
		logic [CW-1:0] rel;
		for (int i = 0; i < b64ld_pkg::RES_DEPTH; i++) begin
			res_d[i] = res_q[i];
		end
		if (pop) begin
			for (int i = 0; i < b64ld_pkg::RES_DEPTH - 1; i++) begin
				res_d[i] = res_q[i + 1];
			end
		end
		for (int i = 0; i < b64ld_pkg::RES_DEPTH; i++) begin
			rel = CW'(i) - cnt_ap;
			if (CW'(i) >= cnt_ap && rel < CW'(push_cnt)) begin
				unique case (rel)
					CW'(0):  res_d[i] = new_res[0];
					CW'(1):  res_d[i] = new_res[1];
					CW'(2):  res_d[i] = new_res[2];
					default: res_d[i] = res_d[i];
				endcase
			end
		end
		cnt_d = cnt_ap + CW'(push_cnt);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= 2'd0;
			acc_q       <= '0;
			third_pad_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			cnt_q <= cnt_d;
			if (accept) begin
				if (pos_q == 2'd3 || s_axis_tlast) begin
					pos_q       <= 2'd0;
					acc_q       <= '0;
					third_pad_q <= 1'b0;
				end else begin
					pos_q <= pos_q + 2'd1;
					acc_q <= {acc_q[11:0], sextet};
					if (pos_q == 2'd2) begin
						third_pad_q <= is_pad;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < b64ld_pkg::RES_DEPTH; i++) begin
			res_q[i] <= res_d[i];
		end
	end

endmodule

FILE: hw/rtl/b64ld_checker.sv
// Port-level checker for the lenient Base64 decoder and its bind.
module b64ld_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_axis_tvalid,
	input logic       s_axis_tready,
	input logic       s_axis_tlast,
	input logic       m_axis_tvalid,
	input logic       m_axis_tready,
	input logic [7:0] m_axis_tdata,
	input logic       m_axis_tlast,
	input logic       m_axis_tuser
);

	// A stalled result request keeps its contents.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tlast) && $stable(m_axis_tuser))
		else $error("result request changed while stalled");

	// An error result ends its message and carries a zero byte.
	a_err_form: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && (m_axis_tdata == 8'h00))
		else $error("malformed length error result");

	// The last character of a message always leaves a result waiting next cycle.
	a_last_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tlast |=> m_axis_tvalid)
		else $error("message end produced no result");

	// Out of reset the queue is empty, so nothing is offered before a character arrives.
	a_reset_empty: assert property (@(posedge clk)
		$rose(arst_n) |-> !m_axis_tvalid)
		else $error("result offered straight after reset");

endmodule

bind base64_lenient_decoder_core b64ld_checker u_b64ld_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tlast  (s_axis_tlast),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast),
	.m_axis_tuser  (m_axis_tuser)
);
